>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the execute unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define RIEU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("execute unit assertion failed");

// Clocked assertion that also holds during reset.
`define RIEU_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("execute unit assertion failed");

`endif

>>> hdl/rieu_pkg.sv
// ---------------------------------------------------------------------------
// Execute unit package
// Types and constants shared by the controller, datapath and top level.
// ---------------------------------------------------------------------------
package rieu_pkg;

   typedef enum logic [5:0] {
      OP_NOP = 6'd0, OP_ADD = 6'd1, OP_SUB = 6'd2, OP_MUL = 6'd3, OP_MULU = 6'd4,
      OP_DIV = 6'd5, OP_MOD = 6'd6, OP_DIVU = 6'd7, OP_MODU = 6'd8, OP_AND = 6'd9,
      OP_ANDI = 6'd10, OP_OR = 6'd11, OP_ORI = 6'd12, OP_NOR = 6'd13, OP_XOR = 6'd14,
      OP_XORI = 6'd15, OP_ADDI = 6'd16, OP_SHR = 6'd17, OP_ASR = 6'd18, OP_SHL = 6'd19,
      OP_SHLR = 6'd20, OP_MOVN = 6'd21, OP_MOVZ = 6'd22, OP_SEH = 6'd23, OP_SEB = 6'd24,
      OP_SLTIU = 6'd25, OP_SLTI = 6'd26, OP_SLTU = 6'd27, OP_SLT = 6'd28, OP_LDI = 6'd29,
      OP_LDIHI = 6'd30, OP_IJMPHI = 6'd31, OP_JEQ = 6'd32, OP_JEQZ = 6'd33,
      OP_JGTZ = 6'd34, OP_JGEZ = 6'd35, OP_JLEZ = 6'd36, OP_JLTZ = 6'd37,
      OP_JNE = 6'd38, OP_JNEZ = 6'd39, OP_CALL = 6'd40, OP_CALLR = 6'd41,
      OP_JUMPR = 6'd42, OP_JUMP = 6'd43
   } op_type;

   typedef struct packed {
      logic [5:0]         operation;
      logic [5:0]         src_index;
      logic [5:0]         tgt_index;
      logic [5:0]         dst_index;
      logic [5:0]         aux_index;
      logic signed [31:0] immediate;
      logic [25:0]        jump_field;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        branch_taken;
      logic        write_enable;
      logic [6:0]  write_index;
      logic [31:0] write_value;
      logic        second_write_enable;
      logic [6:0]  second_write_index;
      logic [31:0] second_write_value;
      logic        divide_by_zero;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_DIV, S_DONE, S_WB2
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic commit;
      logic wb2;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_go;
      logic div_busy;
      logic need_wb2;
   } dp_status_type;

   localparam logic [6:0]  LATCH_IDX   = 7'd64;
   localparam logic [6:0]  BASE_IDX    = 7'd65;
   localparam logic [5:0]  LINK_REG    = 6'd31;
   localparam logic [31:0] IMM_LO_MASK = 32'h0000_3FFF;
   localparam logic [31:0] HI_KEEP     = 32'hFFFF_C000;
   localparam logic [31:0] PC_REGION   = 32'hF000_0000;
   localparam logic [31:0] PC_STEP     = 32'd4;

endpackage

>>> hdl/rieu_div.sv
// ---------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring divider producing one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rieu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic        busy_ff, busy_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] partial;
   logic [32:0] diff;
   logic        ge;

   always_comb begin
      partial  = {rem_ff, quo_ff[31]};
      diff     = partial - {1'b0, dvs_ff};
      ge       = (partial >= {1'b0, dvs_ff});
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[31:0] : partial[31:0];
         quo_in   = {quo_ff[30:0], ge};
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

>>> hdl/rieu_dp.sv
// ---------------------------------------------------------------------------
// Execute unit datapath
// Register file, architectural registers, multiplier, divider and result.
// ---------------------------------------------------------------------------
module rieu_dp #(
   parameter int NUM_REGS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rieu_pkg::req_type     req_payload,
   input  logic                  csr_write_enable,
   input  logic [31:0]           csr_write_data,
   input  rieu_pkg::ctrl_cmd_type cmd,
   output rieu_pkg::dp_status_type status,
   output rieu_pkg::rsp_type     rsp_payload
);
   import rieu_pkg::*;

   localparam int         IDX_W = (NUM_REGS > 32) ? 6 : 5;
   localparam logic [6:0] NREGS = 7'(NUM_REGS);

   logic [31:0]         mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [31:0]         rd_a_ff, rd_b_ff;
   logic                ok_a_ff, ok_b_ff;
   req_type             instr_ff;
   logic [31:0]         pc_ff, pc_in;
   logic [5:0]          latch_ff;
   logic [63:0]         prod_ff;
   rsp_type             rsp_ff, rsp_in;
   logic [6:0]          w2_idx_ff;
   logic [31:0]         w2_val_ff;

   logic [5:0]  addr_a;
   logic [31:0] a, b, imm, seq, btarget, jtarget;
   logic [4:0]  sh;
   op_type      op;
   logic        is_div_op, is_signed_div;
   logic [31:0] mag_a, mag_b, quo_u, rem_u, quo_s, rem_s;
   logic        div_busy;
   logic        f_req, s_req, cond, is_branch;
   logic [5:0]  f_idx, s_idx;
   logic [31:0] f_val, s_val;
   logic        wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0] wr_data;

   function automatic logic in_range(input logic [5:0] idx);
      in_range = ({1'b0, idx} < NREGS);
   endfunction

   assign addr_a = (op_type'(req_payload.operation) == OP_LDIHI) ? latch_ff
                                                                 : req_payload.src_index;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         instr_ff <= req_payload;
         rd_a_ff  <= mem[addr_a[IDX_W-1:0]];
         rd_b_ff  <= mem[req_payload.tgt_index[IDX_W-1:0]];
         ok_a_ff  <= in_range(addr_a) && valid_ff[addr_a[IDX_W-1:0]];
         ok_b_ff  <= in_range(req_payload.tgt_index)
                     && valid_ff[req_payload.tgt_index[IDX_W-1:0]];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign a   = ok_a_ff ? rd_a_ff : '0;
   assign b   = ok_b_ff ? rd_b_ff : '0;
   assign imm = instr_ff.immediate;
   assign op  = op_type'(instr_ff.operation);
   assign sh  = instr_ff.src_index[4:0];
   assign seq = pc_ff + PC_STEP;
   assign btarget = seq + {imm[29:0], 2'b00};
   assign jtarget = (pc_ff & PC_REGION) | {4'b0000, instr_ff.jump_field, 2'b00};

   assign is_div_op     = (op == OP_DIV) || (op == OP_MOD) || (op == OP_DIVU)
                          || (op == OP_MODU);
   assign is_signed_div = (op == OP_DIV) || (op == OP_MOD);
   assign mag_a = (is_signed_div && a[31]) ? (32'd0 - a) : a;
   assign mag_b = (is_signed_div && b[31]) ? (32'd0 - b) : b;

   rieu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (mag_a),
      .divisor   (mag_b),
      .busy      (div_busy),
      .quotient  (quo_u),
      .remainder (rem_u)
   );

   assign quo_s = ((a[31] ^ b[31]) && is_signed_div) ? (32'd0 - quo_u) : quo_u;
   assign rem_s = (a[31] && is_signed_div) ? (32'd0 - rem_u) : rem_u;

   always_ff @(posedge clock) begin
      if (op == OP_MUL) begin
         prod_ff <= 64'($signed({a[31], a}) * $signed({b[31], b}));
      end else begin
         prod_ff <= {32'd0, a} * {32'd0, b};
      end
   end

   always_comb begin
      f_req = 1'b0;
      f_idx = instr_ff.dst_index;
      f_val = '0;
      s_req = 1'b0;
      s_idx = instr_ff.aux_index;
      s_val = prod_ff[63:32];
      cond  = 1'b0;
      pc_in = seq;
      rsp_in = '0;
      unique case (op)
         OP_ADD:  begin f_req = 1'b1; f_val = a + b; end
         OP_SUB:  begin f_req = 1'b1; f_val = a - b; end
         OP_MUL, OP_MULU: begin
            f_req = (instr_ff.dst_index != '0);
            f_val = prod_ff[31:0];
            s_req = (instr_ff.aux_index != '0);
         end
         OP_DIV, OP_DIVU: begin f_req = (b != '0); f_val = quo_s; end
         OP_MOD, OP_MODU: begin
            f_req = (b != '0);
            f_idx = instr_ff.aux_index;
            f_val = rem_s;
         end
         OP_AND:  begin f_req = 1'b1; f_val = a & b; end
         OP_ANDI: begin f_req = 1'b1; f_idx = instr_ff.tgt_index; f_val = a & (imm & IMM_LO_MASK); end
         OP_OR:   begin f_req = 1'b1; f_val = a | b; end
         OP_ORI:  begin f_req = 1'b1; f_idx = instr_ff.tgt_index; f_val = a | (imm & IMM_LO_MASK); end
         OP_NOR:  begin f_req = 1'b1; f_val = ~(a | b); end
         OP_XOR:  begin f_req = 1'b1; f_val = a ^ b; end
         OP_XORI: begin f_req = 1'b1; f_idx = instr_ff.tgt_index; f_val = a ^ (imm & IMM_LO_MASK); end
         OP_ADDI: begin f_req = 1'b1; f_idx = instr_ff.tgt_index; f_val = a + imm; end
         OP_SHR:  begin f_req = 1'b1; f_val = b >> sh; end
         OP_ASR:  begin f_req = 1'b1; f_val = $unsigned($signed(b) >>> sh); end
         OP_SHL:  begin f_req = 1'b1; f_val = b << sh; end
         OP_SHLR: begin f_req = 1'b1; f_val = b << a[4:0]; end
         OP_MOVN: begin f_req = (b != '0); f_val = a; end
         OP_MOVZ: begin f_req = (b == '0); f_val = a; end
         OP_SEH:  begin f_req = 1'b1; f_idx = instr_ff.src_index; f_val = {{16{b[15]}}, b[15:0]}; end
         OP_SEB:  begin f_req = 1'b1; f_idx = instr_ff.src_index; f_val = {{24{b[7]}}, b[7:0]}; end
         OP_SLTIU: begin
            f_req = 1'b1; f_idx = instr_ff.tgt_index;
            f_val = {31'd0, (a < (imm & IMM_LO_MASK))};
         end
         OP_SLTI: begin
            f_req = 1'b1; f_idx = instr_ff.tgt_index;
            f_val = {31'd0, ($signed(a) < $signed(imm))};
         end
         OP_SLTU: begin f_req = 1'b1; f_val = {31'd0, (a < b)}; end
         OP_SLT:  begin f_req = 1'b1; f_val = {31'd0, ($signed(a) < $signed(b))}; end
         OP_LDI: begin
            f_req = 1'b1; f_idx = instr_ff.tgt_index;
            f_val = (b & HI_KEEP) | (imm & IMM_LO_MASK);
         end
         OP_LDIHI: begin
            f_req = 1'b1; f_idx = latch_ff;
            f_val = {instr_ff.jump_field[17:0], a[13:0]};
         end
         OP_JEQ:  cond = (a == b);
         OP_JEQZ: cond = (a == '0);
         OP_JGTZ: cond = !b[31] && (b != '0);
         OP_JGEZ: cond = !b[31];
         OP_JLEZ: cond = (b == '0) || b[31];
         OP_JLTZ: cond = b[31];
         OP_JNE:  cond = (a != b);
         OP_JNEZ: cond = (a != '0);
         OP_CALL: begin
            f_req = 1'b1; f_idx = LINK_REG; f_val = seq;
            pc_in = jtarget; rsp_in.branch_taken = 1'b1;
         end
         OP_CALLR: begin
            f_req = 1'b1; f_idx = LINK_REG; f_val = seq;
            pc_in = (instr_ff.tgt_index == LINK_REG) ? seq : b;
            rsp_in.branch_taken = 1'b1;
         end
         OP_JUMPR: begin pc_in = b; rsp_in.branch_taken = 1'b1; end
         OP_JUMP:  begin pc_in = jtarget; rsp_in.branch_taken = 1'b1; end
         default: ;
      endcase
      is_branch = (instr_ff.operation >= OP_JEQ) && (instr_ff.operation <= OP_JNEZ);
      if (is_branch && cond) begin
         pc_in = btarget;
         rsp_in.branch_taken = 1'b1;
      end
      rsp_in.next_pc = pc_in;
      rsp_in.divide_by_zero = is_div_op && (b == '0);
      if (op == OP_IJMPHI) begin
         rsp_in.write_enable = 1'b1;
         rsp_in.write_index  = BASE_IDX;
         rsp_in.write_value  = {instr_ff.jump_field[19:0], 12'd0};
      end else if (f_req && in_range(f_idx)) begin
         rsp_in.write_enable = 1'b1;
         rsp_in.write_index  = {1'b0, f_idx};
         rsp_in.write_value  = f_val;
      end
      if (op == OP_LDI) begin
         rsp_in.second_write_enable = 1'b1;
         rsp_in.second_write_index  = LATCH_IDX;
         rsp_in.second_write_value  = {26'd0, instr_ff.tgt_index};
      end else if (s_req && in_range(s_idx)) begin
         rsp_in.second_write_enable = 1'b1;
         rsp_in.second_write_index  = {1'b0, s_idx};
         rsp_in.second_write_value  = s_val;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rsp_in.write_index[IDX_W-1:0];
      wr_data = rsp_in.write_value;
      if (cmd.commit) begin
         wr_en = rsp_in.write_enable && !rsp_in.write_index[6];
      end else if (cmd.wb2) begin
         wr_en   = 1'b1;
         wr_addr = w2_idx_ff[IDX_W-1:0];
         wr_data = w2_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         latch_ff <= '0;
      end else if (csr_write_enable) begin
         pc_ff <= csr_write_data;
      end else if (cmd.commit) begin
         pc_ff <= pc_in;
         if (op == OP_LDI) begin
            latch_ff <= instr_ff.tgt_index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff    <= rsp_in;
         w2_idx_ff <= rsp_in.second_write_index;
         w2_val_ff <= rsp_in.second_write_value;
      end
   end

   assign status.div_go   = is_div_op && (b != '0);
   assign status.div_busy = div_busy;
   assign status.need_wb2 = rsp_in.second_write_enable && !rsp_in.second_write_index[6];
   assign rsp_payload     = rsp_ff;
endmodule

>>> hdl/rieu_ctrl.sv
// ---------------------------------------------------------------------------
// Execute unit controller
// Sequences load, execute, divide, commit and second write-back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rieu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rieu_pkg::dp_status_type status,
   output rieu_pkg::ctrl_cmd_type  cmd
);
   import rieu_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            state_in = S_EXEC;
         end
         S_EXEC: state_in = status.div_go ? S_DIV : S_DONE;
         S_DIV:  if (!status.div_busy) begin
            state_in = S_DONE;
         end
         S_DONE: if (out_free) begin
            state_in = status.need_wb2 ? S_WB2 : S_IDLE;
         end
         S_WB2:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      cmd.load      = (state_ff == S_IDLE) && req_valid;
      cmd.div_start = (state_ff == S_EXEC) && status.div_go;
      cmd.commit    = (state_ff == S_DONE) && out_free;
      cmd.wb2       = (state_ff == S_WB2);
      rsp_valid_in  = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RIEU_ASSERT(a_commit_free, clock, reset, cmd.commit |-> (!rsp_valid_ff || rsp_ready))
   `RIEU_ASSERT(a_div_starts, clock, reset, cmd.div_start |=> status.div_busy)
   `RIEU_ASSERT(a_wb2_after_commit, clock, reset, (state_ff == S_WB2) |-> rsp_valid_ff)
endmodule

>>> hdl/risc_integer_execute_unit_core.sv
// Sequencing: a request is taken in the idle state, then passes the execute
// state, the divide state for a divide or modulo with a non-zero divisor, and
// the done state. No new request is taken before it is through, or before a
// multiply writes its high half through the single register-file write port.
// Reset: synchronous; the register file reads as zero at once through valid bits.
// ---------------------------------------------------------------------------
// Integer execute unit core
// Executes one decoded integer instruction per request transfer.
// ---------------------------------------------------------------------------
module risc_integer_execute_unit_core #(
   parameter int NUM_REGS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rieu_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rieu_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic [31:0]       csr_write_data
);
   import rieu_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rieu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rieu_dp #(.NUM_REGS(NUM_REGS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_payload      (rsp_payload)
   );
endmodule

>>> dv/tb_risc_integer_execute_unit_core.sv
// ---------------------------------------------------------------------------
// Execute unit core testbench
// Drives decoded instructions into the execute unit and compares every
// result against a predictor that keeps its own copy of the register file,
// program counter, load-immediate latch and indirect-jump base.
// ---------------------------------------------------------------------------
module tb_risc_integer_execute_unit_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rieu_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_payload;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   logic [31:0] arch_regs [64];
   logic [31:0] arch_pc;
   logic [5:0]  arch_latch;
   logic [31:0] arch_base;
   rsp_type     pending_results [$];
   int          error_count;
   int          hold_cycles;
   bit          rsp_long_hold;

   risc_integer_execute_unit_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic void write_first(ref rsp_type r, input logic [5:0] idx,
                                       input logic [31:0] val);
      arch_regs[idx] = val;
      r.write_enable = 1'b1;
      r.write_index  = {1'b0, idx};
      r.write_value  = val;
   endfunction

   function automatic void write_second(ref rsp_type r, input logic [5:0] idx,
                                        input logic [31:0] val);
      arch_regs[idx] = val;
      r.second_write_enable = 1'b1;
      r.second_write_index  = {1'b0, idx};
      r.second_write_value  = val;
   endfunction

   function automatic logic [31:0] magnitude(logic [31:0] x);
      return x[31] ? -x : x;
   endfunction

   function automatic rsp_type execute_instruction(req_type q);
      rsp_type     r;
      logic [31:0] a, b, imm, seq, q_val, r_val, sval;
      logic [63:0] prod;
      logic [4:0]  sh;
      logic        cond;
      op_type      op;
      r    = '0;
      op   = op_type'(q.operation);
      a    = arch_regs[q.src_index];
      b    = arch_regs[q.tgt_index];
      imm  = q.immediate;
      seq  = arch_pc + PC_STEP;
      sh   = q.src_index[4:0];
      cond = 1'b0;
      r.next_pc = seq;
      case (op)
         OP_ADD:  write_first(r, q.dst_index, a + b);
         OP_SUB:  write_first(r, q.dst_index, a - b);
         OP_MUL, OP_MULU: begin
            if (op == OP_MUL) begin
               prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            end else begin
               prod = {32'd0, a} * {32'd0, b};
            end
            if (q.dst_index != 0) write_first(r, q.dst_index, prod[31:0]);
            if (q.aux_index != 0) write_second(r, q.aux_index, prod[63:32]);
         end
         OP_DIV, OP_MOD: begin
            if (b == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               q_val = magnitude(a) / magnitude(b);
               r_val = magnitude(a) % magnitude(b);
               if (a[31] ^ b[31]) q_val = -q_val;
               if (a[31]) r_val = -r_val;
               if (op == OP_DIV) write_first(r, q.dst_index, q_val);
               else write_first(r, q.aux_index, r_val);
            end
         end
         OP_DIVU: begin
            if (b == 0) r.divide_by_zero = 1'b1;
            else write_first(r, q.dst_index, a / b);
         end
         OP_MODU: begin
            if (b == 0) r.divide_by_zero = 1'b1;
            else write_first(r, q.aux_index, a % b);
         end
         OP_AND:   write_first(r, q.dst_index, a & b);
         OP_ANDI:  write_first(r, q.tgt_index, a & (imm & IMM_LO_MASK));
         OP_OR:    write_first(r, q.dst_index, a | b);
         OP_ORI:   write_first(r, q.tgt_index, a | (imm & IMM_LO_MASK));
         OP_NOR:   write_first(r, q.dst_index, ~(a | b));
         OP_XOR:   write_first(r, q.dst_index, a ^ b);
         OP_XORI:  write_first(r, q.tgt_index, a ^ (imm & IMM_LO_MASK));
         OP_ADDI:  write_first(r, q.tgt_index, a + imm);
         OP_SHR:   write_first(r, q.dst_index, b >> sh);
         OP_ASR:   write_first(r, q.dst_index, $signed(b) >>> sh);
         OP_SHL:   write_first(r, q.dst_index, b << sh);
         OP_SHLR:  write_first(r, q.dst_index, b << a[4:0]);
         OP_MOVN:  if (b != 0) write_first(r, q.dst_index, a);
         OP_MOVZ:  if (b == 0) write_first(r, q.dst_index, a);
         OP_SEH:   write_first(r, q.src_index, {{16{b[15]}}, b[15:0]});
         OP_SEB:   write_first(r, q.src_index, {{24{b[7]}}, b[7:0]});
         OP_SLTIU: write_first(r, q.tgt_index, {31'd0, a < (imm & IMM_LO_MASK)});
         OP_SLTI:  write_first(r, q.tgt_index, {31'd0, $signed(a) < $signed(imm)});
         OP_SLTU:  write_first(r, q.dst_index, {31'd0, a < b});
         OP_SLT:   write_first(r, q.dst_index, {31'd0, $signed(a) < $signed(b)});
         OP_LDI: begin
            write_first(r, q.tgt_index, (b & HI_KEEP) | (imm & IMM_LO_MASK));
            arch_latch = q.tgt_index;
            r.second_write_enable = 1'b1;
            r.second_write_index  = LATCH_IDX;
            r.second_write_value  = {26'd0, q.tgt_index};
         end
         OP_LDIHI: begin
            sval = (arch_regs[arch_latch] & IMM_LO_MASK) | {q.jump_field[17:0], 14'd0};
            write_first(r, arch_latch, sval);
         end
         OP_IJMPHI: begin
            arch_base     = {q.jump_field[19:0], 12'd0};
            r.write_enable = 1'b1;
            r.write_index  = BASE_IDX;
            r.write_value  = arch_base;
         end
         OP_JEQ:  cond = (a == b);
         OP_JEQZ: cond = (a == 0);
         OP_JGTZ: cond = !b[31] && b != 0;
         OP_JGEZ: cond = !b[31];
         OP_JLEZ: cond = (b == 0) || b[31];
         OP_JLTZ: cond = b[31];
         OP_JNE:  cond = (a != b);
         OP_JNEZ: cond = (a != 0);
         OP_CALL: begin
            write_first(r, LINK_REG, seq);
            r.next_pc = (arch_pc & PC_REGION) | {4'd0, q.jump_field, 2'd0};
            r.branch_taken = 1'b1;
         end
         OP_CALLR: begin
            write_first(r, LINK_REG, seq);
            r.next_pc = arch_regs[q.tgt_index];
            r.branch_taken = 1'b1;
         end
         OP_JUMPR: begin
            r.next_pc = b;
            r.branch_taken = 1'b1;
         end
         OP_JUMP: begin
            r.next_pc = (arch_pc & PC_REGION) | {4'd0, q.jump_field, 2'd0};
            r.branch_taken = 1'b1;
         end
         default: ;
      endcase
      if (cond) begin
         r.next_pc = seq + (imm << 2);
         r.branch_taken = 1'b1;
      end
      arch_pc = r.next_pc;
      return r;
   endfunction

   task automatic send_instruction(req_type q);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= q;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(execute_instruction(q));
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic set_start_pc(logic [31:0] value);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      arch_pc = value;
   endtask

   function automatic req_type random_instruction(int op_low, int op_high);
      req_type q;
      int      roll;
      q.operation  = 6'($urandom_range(op_high, op_low));
      q.src_index  = 6'($urandom_range(0, 63));
      q.tgt_index  = 6'($urandom_range(0, 63));
      q.dst_index  = 6'($urandom_range(0, 63));
      q.aux_index  = 6'($urandom_range(0, 63));
      roll = $urandom_range(0, 3);
      if (roll == 0) q.immediate = $signed($urandom_range(0, 40)) - 20;
      else q.immediate = $urandom;
      q.jump_field = 26'($urandom);
      return q;
   endfunction

   function automatic req_type make_instruction(op_type op, int rs, int rt, int rd, int rv,
                                                logic [31:0] imm, int jf);
      req_type q;
      q.operation  = op;
      q.src_index  = 6'(rs);
      q.tgt_index  = 6'(rt);
      q.dst_index  = 6'(rd);
      q.aux_index  = 6'(rv);
      q.immediate  = imm;
      q.jump_field = 26'(jf);
      return q;
   endfunction

   task automatic load_register(int idx, logic [31:0] value);
      send_instruction(make_instruction(OP_LDI, 0, idx, 0, 0, value & IMM_LO_MASK, 0));
      send_instruction(make_instruction(OP_LDIHI, 0, 0, 0, 0, 0, int'(value[31:14])));
   endtask

   task automatic test_directed_cases();
      load_register(1, 32'h8000_0000);
      load_register(2, 32'hFFFF_FFFF);
      load_register(3, 32'h7FFF_FFFF);
      send_instruction(make_instruction(OP_DIV, 1, 2, 4, 5, 0, 0));
      send_instruction(make_instruction(OP_MOD, 1, 2, 4, 5, 0, 0));
      send_instruction(make_instruction(OP_DIVU, 1, 6, 4, 5, 0, 0));
      send_instruction(make_instruction(OP_MOD, 1, 6, 4, 5, 0, 0));
      send_instruction(make_instruction(OP_MUL, 1, 2, 7, 7, 0, 0));
      send_instruction(make_instruction(OP_MULU, 2, 2, 0, 8, 0, 0));
      send_instruction(make_instruction(OP_MUL, 3, 3, 9, 0, 0, 0));
      send_instruction(make_instruction(OP_ASR, 63, 1, 10, 0, 0, 0));
      send_instruction(make_instruction(OP_SHLR, 2, 3, 11, 0, 0, 0));
      send_instruction(make_instruction(OP_ADDI, 3, 63, 0, 0, 32'h7FFF_FFFF, 0));
      send_instruction(make_instruction(OP_SLTI, 1, 12, 0, 0, 32'h8000_0000, 0));
      send_instruction(make_instruction(OP_CALLR, 0, int'(LINK_REG), 0, 0, 0, 0));
      send_instruction(make_instruction(OP_CALL, 0, 0, 0, 0, 0, 32'h03FF_FFFF));
      send_instruction(make_instruction(OP_IJMPHI, 0, 0, 0, 0, 0, 32'h03FF_FFFF));
      send_instruction(make_instruction(OP_JNE, 1, 2, 0, 0, 32'hFFFF_FFFF, 0));
      send_instruction(make_instruction(OP_JUMPR, 0, 2, 0, 0, 0, 0));
      send_instruction(make_instruction(op_type'(6'd63), 63, 63, 63, 63, '1, -1));
   endtask

   task automatic test_random_mix(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_instruction(random_instruction(5, 8));
         end else begin
            send_instruction(random_instruction(0, 63));
         end
      end
   endtask

   task automatic test_backpressure();
      rsp_long_hold = 1'b1;
      test_random_mix(20);
      rsp_long_hold = 1'b0;
      wait_for_results();
      test_random_mix(20);
   endtask

   task automatic test_start_pc_settings();
      set_start_pc(32'hFFFF_FFFC);
      test_random_mix(60);
      set_start_pc(32'h0000_0000);
      test_random_mix(60);
      set_start_pc(32'hFFFF_FFFF);
      test_random_mix(60);
      set_start_pc($urandom);
      test_random_mix(60);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      error_count      = 0;
      rsp_long_hold    = 1'b0;
      foreach (arch_regs[i]) arch_regs[i] = '0;
      arch_pc    = '0;
      arch_latch = '0;
      arch_base  = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_cases();
      test_backpressure();
      test_random_mix(200);
      test_start_pc_settings();
      test_random_mix(160);
      wait_for_results();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_long_hold) begin
            rsp_ready <= 1'b0;
            hold_cycles = 0;
            while (hold_cycles < 300) begin
               @(negedge clock);
               hold_cycles++;
            end
            rsp_ready <= 1'b1;
            while (rsp_long_hold) @(negedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_length() + 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected transfer: actual %p", $time, rsp_payload);
            error_count++;
         end else begin
            expected = pending_results.pop_front();
            if (rsp_payload !== expected) begin
               $display("%0t mismatch: expected %p actual %p", $time, expected,
                        rsp_payload);
               error_count++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
